// ----- hw/rtl/pbc_pkg.sv -----
`timescale 1ns / 1ps

package pbc_pkg;

	// coordinate fields are fixed at ten bits on the stream
	localparam int COORD_BITS = 10;
	// one extra bit so that far edges and right or bottom neighbour cells never wrap
	localparam int CW         = COORD_BITS + 1;
	localparam int SLOT_BITS  = 4;
	localparam int CFG_IDX_BITS = 2;

	localparam int S_TDATA_BITS = 72;
	localparam int M_TDATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_MODE     = 2'd2;

	localparam logic [COORD_BITS-1:0] WINDOW_WIDTH_RST  = 10'd79;
	localparam logic [COORD_BITS-1:0] WINDOW_HEIGHT_RST = 10'd23;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		KIND_INSIDE     = 4'd0,
		KIND_VERTICAL   = 4'd1,
		KIND_HORIZONTAL = 4'd2,
		KIND_CORNER_TL  = 4'd3,
		KIND_CORNER_TR  = 4'd4,
		KIND_CORNER_BL  = 4'd5,
		KIND_CORNER_BR  = 4'd6,
		KIND_JOIN_TOP   = 4'd7,
		KIND_JOIN_BOT   = 4'd8,
		KIND_JOIN_LEFT  = 4'd9,
		KIND_JOIN_RIGHT = 4'd10,
		KIND_CROSS      = 4'd11,
		KIND_OUTSIDE    = 4'd12
	} kind_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} geom_t;

	typedef struct packed {
		logic                  is_query;
		logic [SLOT_BITS-1:0]  slot;
		geom_t                 geom;
		logic                  vis;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
	} cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] win_w;
		logic [COORD_BITS-1:0] win_h;
		logic                  line_mode;
	} cfg_t;

	// neighbour mask: left=8, right=4, top=2, bottom=1
	function automatic kind_t mask_kind(input logic [3:0] m);
		kind_t k;
		case (m)
			4'd3:    k = KIND_VERTICAL;
			4'd5:    k = KIND_CORNER_TL;
			4'd6:    k = KIND_CORNER_BL;
			4'd7:    k = KIND_JOIN_LEFT;
			4'd9:    k = KIND_CORNER_TR;
			4'd10:   k = KIND_CORNER_BR;
			4'd11:   k = KIND_JOIN_RIGHT;
			4'd12:   k = KIND_HORIZONTAL;
			4'd13:   k = KIND_JOIN_TOP;
			4'd14:   k = KIND_JOIN_BOT;
			4'd15:   k = KIND_CROSS;
			default: k = KIND_OUTSIDE;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] glyph_lines(input kind_t k);
		logic [7:0] g;
		case (k)
			KIND_INSIDE:     g = 8'h20;
			KIND_VERTICAL:   g = 8'h78;
			KIND_HORIZONTAL: g = 8'h71;
			KIND_CORNER_TL:  g = 8'h6c;
			KIND_CORNER_TR:  g = 8'h6b;
			KIND_CORNER_BL:  g = 8'h6d;
			KIND_CORNER_BR:  g = 8'h6a;
			KIND_JOIN_TOP:   g = 8'h77;
			KIND_JOIN_BOT:   g = 8'h76;
			KIND_JOIN_LEFT:  g = 8'h74;
			KIND_JOIN_RIGHT: g = 8'h75;
			KIND_CROSS:      g = 8'h6e;
			default:         g = 8'h7e;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] glyph_ascii(input kind_t k);
		logic [7:0] g;
		case (k)
			KIND_INSIDE:     g = 8'h20;
			KIND_VERTICAL:   g = 8'h7c;
			KIND_HORIZONTAL: g = 8'h2d;
			KIND_JOIN_TOP:   g = 8'h2d;
			KIND_JOIN_BOT:   g = 8'h2d;
			KIND_JOIN_LEFT:  g = 8'h7c;
			KIND_JOIN_RIGHT: g = 8'h7c;
			KIND_CROSS:      g = 8'h2b;
			default:         g = 8'h2e;
		endcase
		return g;
	endfunction

endpackage

// ----- hw/rtl/pbc_front.sv -----
`timescale 1ns / 1ps

module pbc_front #(
	parameter int MAX_PANES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pbc_pkg::S_TDATA_BITS-1:0]  s_tdata,
	input  logic                              s_tuser,
	output logic                              q_valid,
	output pbc_pkg::cmd_t                     q_cmd,
	input  logic                              q_pop
);
	import pbc_pkg::*;

	localparam int Q_DEPTH = 4;
	localparam int PTR_W   = $clog2(Q_DEPTH);

	cmd_t                cmd;
	logic                keep;
	logic                push;
	cmd_t                q_mem [Q_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      count_q;

	// unpack the beat
	always_comb begin
		cmd.is_query = (s_tuser == FUNC_QUERY);
		cmd.slot     = s_tdata[3:0];
		cmd.geom.x   = s_tdata[13:4];
		cmd.geom.y   = s_tdata[23:14];
		cmd.geom.w   = s_tdata[33:24];
		cmd.geom.h   = s_tdata[43:34];
		cmd.vis      = s_tdata[44];
		cmd.cx       = s_tdata[54:45];
		cmd.cy       = s_tdata[64:55];
	end

	// writes to slots the table does not have are dropped here
	assign keep     = cmd.is_query || (32'(cmd.slot) < MAX_PANES);
	assign s_tready = (count_q != (PTR_W+1)'(Q_DEPTH));
	assign push     = s_tvalid && s_tready && keep;
	assign q_valid  = (count_q != '0);
	assign q_cmd    = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/pbc_back.sv -----
`timescale 1ns / 1ps

module pbc_back #(
	parameter int MAX_PANES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pbc_pkg::cfg_t                     cfg,
	input  logic                              q_valid,
	input  pbc_pkg::cmd_t                     q_cmd,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pbc_pkg::M_TDATA_BITS-1:0]  m_tdata
);
	import pbc_pkg::*;

	localparam int IDX_W = (MAX_PANES > 1) ? $clog2(MAX_PANES) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int NPOS  = 5;
	// cell positions tested side by side
	localparam int POS_C = 0;
	localparam int POS_L = 1;
	localparam int POS_R = 2;
	localparam int POS_T = 3;
	localparam int POS_B = 4;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      issue_q;
	logic [MAX_PANES-1:0]  vis_q;
	geom_t                 geom_mem [MAX_PANES];
	geom_t                 geom_s1;
	logic                  rd_vld_s1;
	logic                  last_s1;
	logic                  vis_s1;
	logic [NPOS-1:0]       dec_q;
	logic [NPOS-1:0]       bord_q;
	logic                  hit_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;

	logic [IDX_W-1:0]      wr_idx;
	logic [IDX_W-1:0]      rd_idx;
	logic                  wr_en;
	logic                  start;
	logic                  issue;
	logic                  load;
	logic [CW-1:0]         pos_x [NPOS];
	logic [CW-1:0]         pos_y [NPOS];
	logic [2:0]            res [NPOS];
	logic [3:0]            mask;
	kind_t                 kind;
	logic [7:0]            glyph;

	// returns {inside, on frame edge, within grown rectangle}
	function automatic logic [2:0] pane_test(
		input logic [CW-1:0] px, input logic [CW-1:0] py, input geom_t g);
		logic [CW-1:0] x, y, xe, ye, px1, py1;
		logic in_pane, xr, yr, vedge, hedge;
		x     = CW'(g.x);
		y     = CW'(g.y);
		xe    = CW'(g.x) + CW'(g.w);
		ye    = CW'(g.y) + CW'(g.h);
		px1   = px + 1'b1;
		py1   = py + 1'b1;
		in_pane = (px >= x) && (px < xe) && (py >= y) && (py < ye);
		xr    = ((g.x == '0) || (px1 >= x)) && (px <= xe);
		yr    = ((g.y == '0) || (py1 >= y)) && (py <= ye);
		vedge = yr && (((g.x != '0) && (px1 == x)) || (px == xe));
		hedge = xr && (((g.y != '0) && (py1 == y)) || (py == ye));
		return {in_pane, vedge || hedge, xr && yr};
	endfunction

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign wr_en  = q_pop && !q_cmd.is_query;
	assign start  = q_pop && q_cmd.is_query;
	assign wr_idx = IDX_W'(q_cmd.slot);
	assign issue  = (state_q == ST_SCAN) && (issue_q < CNT_W'(MAX_PANES));
	assign rd_idx = issue_q[IDX_W-1:0];
	assign load   = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	always_comb begin
		pos_x[POS_C] = CW'(cx_q);          pos_y[POS_C] = CW'(cy_q);
		pos_x[POS_L] = CW'(cx_q) - 1'b1;   pos_y[POS_L] = CW'(cy_q);
		pos_x[POS_R] = CW'(cx_q) + 1'b1;   pos_y[POS_R] = CW'(cy_q);
		pos_x[POS_T] = CW'(cx_q);          pos_y[POS_T] = CW'(cy_q) - 1'b1;
		pos_x[POS_B] = CW'(cx_q);          pos_y[POS_B] = CW'(cy_q) + 1'b1;
		for (int j = 0; j < NPOS; j++) begin
			res[j] = pane_test(pos_x[j], pos_y[j], geom_s1);
		end
	end

	// off the left or top edge counts as border
	assign mask = {(cx_q == '0) || bord_q[POS_L], bord_q[POS_R],
		(cy_q == '0) || bord_q[POS_T], bord_q[POS_B]};

	always_comb begin
		if ((cx_q > cfg.win_w) || (cy_q > cfg.win_h) || !hit_q) begin
			kind = KIND_OUTSIDE;
		end else if (!bord_q[POS_C]) begin
			kind = KIND_INSIDE;
		end else begin
			kind = mask_kind(mask);
		end
		glyph = cfg.line_mode ? glyph_lines(kind) : glyph_ascii(kind);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			geom_mem[wr_idx] <= q_cmd.geom;
		end
	end

	always_ff @(posedge clk) begin
		geom_s1 <= geom_mem[rd_idx];
		if (start) begin
			cx_q <= q_cmd.cx;
			cy_q <= q_cmd.cy;
		end
		if (load) begin
			m_tdata_q <= {4'b0, glyph, 4'(kind)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issue_q    <= '0;
			vis_q      <= '0;
			rd_vld_s1  <= 1'b0;
			last_s1    <= 1'b0;
			vis_s1     <= 1'b0;
			dec_q      <= '0;
			bord_q     <= '0;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (m_tvalid_q && m_tready && !load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (wr_en) begin
						vis_q[wr_idx] <= q_cmd.vis;
					end
					if (start) begin
						state_q <= ST_SCAN;
						issue_q <= '0;
						dec_q   <= '0;
						bord_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_q   <= issue_q + 1'b1;
						vis_s1    <= vis_q[rd_idx];
						last_s1   <= (issue_q == CNT_W'(MAX_PANES - 1));
					end
					if (rd_vld_s1) begin
						if (vis_s1) begin
							// first visible pane that decides a position wins
							for (int j = 0; j < NPOS; j++) begin
								if (!dec_q[j] && (res[j][2] || res[j][1])) begin
									dec_q[j]  <= 1'b1;
									bord_q[j] <= !res[j][2];
								end
							end
							if (res[POS_C][0]) begin
								hit_q <= 1'b1;
							end
						end
						if (last_s1) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- hw/rtl/pane_border_cell_classifier_top.sv -----
`timescale 1ns / 1ps
// pane border cell classifier
// input stream (s_*): one beat per item; tuser is the function, 0 loads a pane
// table slot, 1 asks for the class of a cell. table loads give no output beat.
// output stream (m_*): one beat per query with the cell kind and its glyph.
// configuration: cfg_we/cfg_index/cfg_wdata set window width, window height and
// the glyph set; only write them while no query is in flight.
// the front end decodes beats into a four-entry command queue, so the input
// keeps taking beats while the back end scans or while a result waits.
// the back end walks the pane table one slot per cycle through its registered
// memory port, testing the cell and its four neighbours against that slot at
// once; it takes no new command until a query's result is loaded for output.
// when the receiver stalls the result holds in the output register, the back
// end waits with the next query, and the queue fills before s_tready drops.
// reset: all panes invisible, window 79 by 23, ascii glyphs, queue empty.

module pane_border_cell_classifier_top #(
	parameter int MAX_PANES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pane_slot, pane_x, pane_y, pane_width, pane_height, pane_visible,
	// cell_x, cell_y, zero pad
	input  logic [pbc_pkg::S_TDATA_BITS-1:0]      s_tdata,
	// func
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// cell_kind, glyph, zero pad
	output logic [pbc_pkg::M_TDATA_BITS-1:0]      m_tdata,
	input  logic                                  cfg_we,
	input  logic [pbc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [pbc_pkg::COORD_BITS-1:0]        cfg_wdata
);
	import pbc_pkg::*;

	cfg_t cfg_q;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	// configuration registers, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_w     <= WINDOW_WIDTH_RST;
			cfg_q.win_h     <= WINDOW_HEIGHT_RST;
			cfg_q.line_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_WIDTH:  cfg_q.win_w     <= cfg_wdata;
				CFG_WINDOW_HEIGHT: cfg_q.win_h     <= cfg_wdata;
				CFG_LINE_MODE:     cfg_q.line_mode <= cfg_wdata[0];
				default:           cfg_q           <= cfg_q;
			endcase
		end
	end

	// front end: decode and queue
	pbc_front #(
		.MAX_PANES (MAX_PANES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// back end: pane table, slot scan and output register
	pbc_back #(
		.MAX_PANES (MAX_PANES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- hw/rtl/pbc_checker.sv -----
`timescale 1ns / 1ps

module pbc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pbc_pkg::M_TDATA_BITS-1:0] m_tdata
);
	import pbc_pkg::*;

	// no result beat while in reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output beat during reset");

	// a stalled beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output beat changed");

	// only the thirteen kinds are produced
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= KIND_OUTSIDE)
		else $error("cell kind out of range");

	// inside cells are blank in either glyph set
	a_inside_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] == KIND_INSIDE) |-> m_tdata[11:4] == 8'h20)
		else $error("inside cell with non-blank glyph");

endmodule

bind pane_border_cell_classifier_top pbc_checker u_pbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/pane_border_cell_classifier_top_tb.sv -----
`timescale 1ns / 1ps

module pane_border_cell_classifier_top_tb;
	import pbc_pkg::*;

	localparam int PANES        = 16;
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off so the queue fills
	localparam int DRAIN_CYCLES = 40;      // covers a query latency plus queued loads
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 6;
	localparam int MAX_REPORTS  = 50;

	// one input beat before packing
	typedef struct {
		logic       func;
		logic [3:0] slot;
		logic [9:0] x, y, w, h;
		logic       vis;
		logic [9:0] cx, cy;
	} item_t;

	// directed row: the item and, where obvious, the kind it must give
	typedef struct {
		item_t it;
		bit    typed;
		kind_t kind;
	} row_t;

	// shadow pane geometry, held as plain ints so far edges never wrap
	typedef struct {
		int x, y, w, h;
		bit vis;
	} pane_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] glyph;
	} answer_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata;
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0]   cfg_wdata;

	// shadow of the block state and its registers
	pane_t           panes[PANES];
	int              win_w;
	int              win_h;
	bit              line_mode;

	answer_t         answers_due[$];
	row_t            script[$];

	int              errors;
	int              loads_sent;
	int              queries_sent;
	int              results_seen;
	int              holds_done;
	int              cycles;
	bit              no_gaps;
	bit              hold_req;
	bit [12:0]       kinds_seen;

	// neighbour mask (left=8, right=4, top=2, bottom=1) to kind
	kind_t kind_by_mask[16] = '{
		KIND_OUTSIDE, KIND_OUTSIDE, KIND_OUTSIDE, KIND_VERTICAL,
		KIND_OUTSIDE, KIND_CORNER_TL, KIND_CORNER_BL, KIND_JOIN_LEFT,
		KIND_OUTSIDE, KIND_CORNER_TR, KIND_CORNER_BR, KIND_JOIN_RIGHT,
		KIND_HORIZONTAL, KIND_JOIN_TOP, KIND_JOIN_BOT, KIND_CROSS
	};

	pane_border_cell_classifier_top #(
		.MAX_PANES(PANES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// watchdog
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			answers_due.size());
		$display("pane_border_cell_classifier_top_tb NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// --------------------------------------------------------------------
	// predictor
	// --------------------------------------------------------------------

	// cell lies on the one-cell frame of the first visible pane that claims it;
	// a cell inside an earlier pane stops the search as not-border. with signed
	// ints the offset-minus-one compares need no guard for zero offsets
	function automatic bit frame_hit(input int px, input int py);
		int i;
		int xe, ye;
		for (i = 0; i < PANES; i++) begin
			if (!panes[i].vis)
				continue;
			xe = panes[i].x + panes[i].w;
			ye = panes[i].y + panes[i].h;
			if (px >= panes[i].x && px < xe && py >= panes[i].y && py < ye)
				return 1'b0;
			if (py >= panes[i].y - 1 && py <= ye) begin
				if (px == panes[i].x - 1 || px == xe)
					return 1'b1;
			end
			if (px >= panes[i].x - 1 && px <= xe) begin
				if (py == panes[i].y - 1 || py == ye)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic kind_t classify_cell(input int px, input int py);
		int         i;
		bit         found;
		logic [3:0] m;
		if (px > win_w || py > win_h)
			return KIND_OUTSIDE;
		found = 1'b0;
		for (i = 0; i < PANES; i++) begin
			if (panes[i].vis && px >= panes[i].x - 1 && px <= panes[i].x + panes[i].w &&
					py >= panes[i].y - 1 && py <= panes[i].y + panes[i].h) begin
				found = 1'b1;
				break;
			end
		end
		if (!found)
			return KIND_OUTSIDE;
		if (!frame_hit(px, py))
			return KIND_INSIDE;
		// off the left or top edge counts as border
		m[3] = (px == 0) || frame_hit(px - 1, py);
		m[2] = frame_hit(px + 1, py);
		m[1] = (py == 0) || frame_hit(px, py - 1);
		m[0] = frame_hit(px, py + 1);
		return kind_by_mask[m];
	endfunction

	function automatic logic [7:0] glyph_of(input kind_t k);
		string set;
		set = line_mode ? " xqlkmjwvtun~" : " |-....--||+.";
		return set[int'(k)];
	endfunction

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------

	function automatic row_t load_row(input int slot, input int x, input int y,
			input int w, input int h, input bit vis);
		row_t r;
		r.it = '{FUNC_WRITE, 4'(slot), 10'(x), 10'(y), 10'(w), 10'(h), vis, 10'd0, 10'd0};
		r.typed = 1'b0;
		r.kind = KIND_OUTSIDE;
		return r;
	endfunction

	function automatic row_t ask_row(input int cx, input int cy);
		row_t r;
		r.it = '{FUNC_QUERY, 4'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 10'(cx), 10'(cy)};
		r.typed = 1'b0;
		r.kind = KIND_OUTSIDE;
		return r;
	endfunction

	function automatic row_t ask_known(input int cx, input int cy, input kind_t k);
		row_t r;
		r = ask_row(cx, cy);
		r.typed = 1'b1;
		r.kind = k;
		return r;
	endfunction

	// random beat: mostly queries aimed at the frame of some pane, with small
	// panes near the origin and now and then full-range fields
	function automatic item_t make_item();
		item_t it;
		int    p;
		it.func = ($urandom_range(0, 9) < 7) ? FUNC_QUERY : FUNC_WRITE;
		it.slot = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 7) == 0) begin
			it.x = 10'($urandom_range(0, 1023));
			it.y = 10'($urandom_range(0, 1023));
			it.w = 10'($urandom_range(0, 1023));
			it.h = 10'($urandom_range(0, 1023));
		end else begin
			it.x = 10'($urandom_range(0, 60));
			it.y = 10'($urandom_range(0, 40));
			it.w = 10'($urandom_range(0, 15));
			it.h = 10'($urandom_range(0, 12));
		end
		it.vis = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 9) < 7) begin
			p = $urandom_range(0, PANES - 1);
			it.cx = 10'(panes[p].x - 2 + $urandom_range(0, panes[p].w + 3));
			it.cy = 10'(panes[p].y - 2 + $urandom_range(0, panes[p].h + 3));
		end else begin
			it.cx = 10'($urandom_range(0, 1023));
			it.cy = 10'($urandom_range(0, 1023));
		end
		return it;
	endfunction

	// offer one beat after a random gap, then fold it into the shadow state;
	// a typed kind overrides the predictor for directed rows
	task automatic send_item(input item_t it, input bit typed, input kind_t known);
		int    gap;
		kind_t k;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {7'd0, it.cy, it.cx, it.vis, it.h, it.w, it.y, it.x, it.slot};
		do @(posedge clk); while (!s_tready);
		if (it.func == FUNC_WRITE) begin
			panes[it.slot] = '{int'(it.x), int'(it.y), int'(it.w), int'(it.h), it.vis};
			loads_sent++;
		end else begin
			k = typed ? known : classify_cell(int'(it.cx), int'(it.cy));
			answers_due.push_back('{k, glyph_of(k)});
			queries_sent++;
		end
	endtask

	// registers may only change with nothing in flight; loads give no beat, so
	// after the last result some extra cycles let queued loads retire
	task automatic settle();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input int w, input int h, input bit mode);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WINDOW_WIDTH;
		cfg_wdata <= 10'(w);
		@(posedge clk);
		cfg_index <= CFG_WINDOW_HEIGHT;
		cfg_wdata <= 10'(h);
		@(posedge clk);
		cfg_index <= CFG_LINE_MODE;
		cfg_wdata <= {9'd0, mode};
		@(posedge clk);
		cfg_we <= 1'b0;
		win_w = w;
		win_h = h;
		line_mode = mode;
	endtask

	// --------------------------------------------------------------------
	// result side: random stalls per beat, one long hold-off on request
	// --------------------------------------------------------------------
	initial begin
		int      stall;
		answer_t exp_ans;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, tdata %h",
					m_tdata));
			end else begin
				exp_ans = answers_due.pop_front();
				kinds_seen[exp_ans.kind] = 1'b1;
				if (m_tdata[3:0] !== exp_ans.kind)
					report_mismatch($sformatf("cell_kind %0d, expected %0d (%s)",
						m_tdata[3:0], exp_ans.kind, exp_ans.kind.name()));
				if (m_tdata[11:4] !== exp_ans.glyph)
					report_mismatch($sformatf("glyph %h, expected %h for %s",
						m_tdata[11:4], exp_ans.glyph, exp_ans.kind.name()));
			end
		end
	end

	// --------------------------------------------------------------------
	// main sequence
	// --------------------------------------------------------------------
	initial begin
		int    n;
		int    ph;
		int    pw, ph_h;
		bit    pm;
		int    phase_items[PHASES];
		int    phase_w[PHASES];
		int    phase_h[PHASES];
		bit    phase_m[PHASES];

		phase_items = '{120, 140, 40, 120, 140, 140};
		phase_w     = '{79, 1023, 0, 40, 1023, 0};
		phase_h     = '{23, 1023, 0, 20, 1023, 0};
		phase_m     = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_WINDOW_WIDTH;
		cfg_wdata = '0;
		cycles    = 0;
		errors    = 0;
		no_gaps   = 1'b0;
		hold_req  = 1'b0;
		kinds_seen = '0;
		loads_sent = 0;
		queries_sent = 0;
		results_seen = 0;
		holds_done = 0;
		for (n = 0; n < PANES; n++)
			panes[n] = '{0, 0, 0, 0, 1'b0};
		win_w = 79;
		win_h = 23;
		line_mode = 1'b0;

		// directed rows, run with the reset settings (79 by 23, ascii)
		script.push_back(ask_known(5, 5, KIND_OUTSIDE));          // empty table
		script.push_back(ask_known(0, 0, KIND_OUTSIDE));
		script.push_back(load_row(0, 1, 1, 10, 5, 1'b1));
		script.push_back(ask_known(5, 3, KIND_INSIDE));
		script.push_back(ask_row(0, 0));                           // edges count as border
		script.push_back(ask_known(11, 6, KIND_CORNER_BR));
		script.push_back(ask_known(80, 3, KIND_OUTSIDE));          // one past window width
		script.push_back(load_row(1, 20, 5, 10, 5, 1'b1));
		script.push_back(ask_known(19, 4, KIND_CORNER_TL));
		script.push_back(ask_known(30, 10, KIND_CORNER_BR));
		script.push_back(ask_known(25, 4, KIND_HORIZONTAL));
		script.push_back(ask_known(19, 7, KIND_VERTICAL));
		script.push_back(load_row(2, 31, 5, 5, 5, 1'b1));          // shares a column with slot 1
		script.push_back(ask_row(30, 4));
		script.push_back(ask_row(30, 7));
		script.push_back(ask_row(30, 10));
		script.push_back(load_row(3, 40, 5, 3, 3, 1'b0));          // hidden pane
		script.push_back(ask_known(39, 4, KIND_OUTSIDE));
		script.push_back(load_row(4, 1023, 1023, 1023, 1023, 1'b1)); // far edge past 10 bits
		script.push_back(ask_known(1022, 1022, KIND_OUTSIDE));
		script.push_back(load_row(5, 70, 15, 9, 8, 1'b1));
		script.push_back(ask_row(79, 23));                         // cell equal to window size
		script.push_back(ask_known(1023, 1023, KIND_OUTSIDE));
		script.push_back(ask_row(5, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_item(script[i].it, script[i].typed, script[i].kind);

		// random phases, each under its own window and glyph set
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			pw   = phase_w[ph];
			ph_h = phase_h[ph];
			pm   = phase_m[ph];
			if (ph == PHASES - 1) begin
				pw   = $urandom_range(0, 1023);
				ph_h = $urandom_range(0, 1023);
				pm   = $urandom_range(0, 1);
			end
			write_settings(pw, ph_h, pm);
			for (n = 0; n < phase_items[ph]; n++) begin
				// back-to-back stretch with no idling on either side
				no_gaps = (ph == 3 && n < 60);
				// receiver goes quiet while the sender keeps pushing
				if (ph == 1 && n == 40)
					hold_req = 1'b1;
				send_item(make_item(), 1'b0, KIND_OUTSIDE);
			end
			no_gaps = 1'b0;
		end

		s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d pane loads, %0d queries, %0d results over %0d settings",
			loads_sent, queries_sent, results_seen, PHASES + 1);
		$display("run: %0d of 13 kinds seen, %0d long output hold-offs, %0d mismatches",
			$countones(kinds_seen), holds_done, errors);
		if (errors == 0)
			$display("pane_border_cell_classifier_top_tb OK");
		else
			$display("pane_border_cell_classifier_top_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/pbc_pkg.sv
hw/rtl/pbc_front.sv
hw/rtl/pbc_back.sv
hw/rtl/pane_border_cell_classifier_top.sv
hw/rtl/pbc_checker.sv
tb/pane_border_cell_classifier_top_tb.sv
